@@ rtl/csi_pkg.sv @@
// shared types and codes for the clipmap scroll invalidation block
`default_nettype none

package csi_pkg;

   typedef enum logic [1:0] {
      KIND_POS       = 2'd0,
      KIND_ADD       = 2'd1,
      KIND_REMOVE    = 2'd2,
      KIND_FRAME_END = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_EVAL,
      ST_EMIT,
      ST_WRITE,
      ST_FLUSH
   } state_type;

   localparam int unsigned PAGE_SHIFT_RESET = 4;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic shift;
      logic eval;
      logic load_box;
      logic next_axis;
      logic write;
      logic flush;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic walk;
      logic unchanged;
      logic last_level;
      logic box_here;
      logic axis_last;
      logic room;
      logic pend_valid;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/csi_ctrl.sv @@
// controller state machine for the level walk and box emission
`default_nettype none

module csi_ctrl
   import csi_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && stat.walk) state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (stat.unchanged) state_in = ST_FLUSH;
            else                state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.axis_last && (!stat.box_here || stat.room)) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (stat.last_level) state_in = ST_FLUSH;
            else                 state_in = ST_SHIFT;
         end
         ST_FLUSH: begin
            if (!stat.pend_valid || stat.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_EMIT: begin
            if (stat.box_here) begin
               cmd.load_box  = stat.room;
               cmd.next_axis = stat.room && !stat.axis_last;
            end else begin
               cmd.next_axis = !stat.axis_last;
            end
         end
         ST_WRITE: begin
            cmd.write = 1'b1;
         end
         ST_FLUSH: begin
            cmd.flush = stat.pend_valid && stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/csi_datapath.sv @@
// datapath: camera state, origin memory, page shift, box build and output register
`default_nettype none

module csi_datapath
   import csi_pkg::*;
#(
   parameter int LEVELS         = 7,
   parameter int PAGES_PER_AXIS = 32,
   parameter int CAMERAS        = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [3:0]         csr_wdata,
   input  wire logic [1:0]         req_kind,
   input  wire logic [2:0]         req_camera,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic               req_camera_moved,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_out_camera,
   output logic [2:0]              rsp_out_level,
   output logic signed [31:0]      rsp_box_min_x,
   output logic signed [31:0]      rsp_box_min_y,
   output logic signed [31:0]      rsp_box_min_z,
   output logic signed [31:0]      rsp_box_max_x,
   output logic signed [31:0]      rsp_box_max_y,
   output logic signed [31:0]      rsp_box_max_z,
   output logic                    rsp_last,
   input  wire cmd_type            cmd,
   output stat_type                stat
);

   localparam int CW   = (CAMERAS > 1) ? $clog2(CAMERAS) : 1;
   localparam int CXW  = (CW > 3) ? CW : 3;
   localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int LXW  = (LW > 3) ? LW : 3;
   localparam int DEPTH = CAMERAS * LEVELS;
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic signed [31:0] HALF  = 32'(PAGES_PER_AXIS / 2);
   localparam logic signed [32:0] PAGES = 33'(PAGES_PER_AXIS);

   // configuration and per-camera flags
   logic [3:0]         page_shift_ff;
   logic [CAMERAS-1:0] active_ff;
   logic [CAMERAS-1:0] pending_ff;
   logic [LEVELS-1:0]  known_ff [CAMERAS];

   // walk context
   logic [2:0]         cam_raw_ff;
   logic [CW-1:0]      cam_ff;
   logic [LW-1:0]      lvl_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] c_ff   [3];
   logic [95:0]        rd_ff;
   logic [2:0]         dpos_ff;
   logic [2:0]         dneg_ff;
   logic               full_ff;
   logic [1:0]         axis_ff;

   // pending box, held until it is known whether it is the final one
   logic               pend_valid_ff;
   logic [2:0]         pend_cam_ff;
   logic [2:0]         pend_lvl_ff;
   logic signed [31:0] pend_min_ff [3];
   logic signed [31:0] pend_max_ff [3];

   // output register
   logic               out_valid_ff;
   logic [2:0]         out_cam_ff;
   logic [2:0]         out_lvl_ff;
   logic signed [31:0] out_min_ff [3];
   logic signed [31:0] out_max_ff [3];
   logic               out_last_ff;

   logic [95:0]        mem [DEPTH];

   logic [CXW-1:0]     req_cam_ext;
   logic [CW-1:0]      req_cam_idx;
   logic               req_cam_ok;
   kind_type           kind;
   logic [AW-1:0]      addr;
   logic [4:0]         shamt;
   logic signed [31:0] org [3];
   logic signed [32:0] diff [3];
   logic               jump;
   logic               known_bit;
   logic               same;
   logic               out_free;
   logic               room;
   logic signed [31:0] bmin [3];
   logic signed [31:0] bmax [3];
   logic [LXW-1:0]     lvl_ext;

   assign req_cam_ext = CXW'(req_camera);
   assign req_cam_idx = req_cam_ext[CW-1:0];
   assign req_cam_ok  = {29'd0, req_camera} < 32'(CAMERAS);
   assign kind        = kind_type'(req_kind);

   assign addr      = AW'(32'(cam_ff) * 32'(LEVELS) + 32'(lvl_ff));
   assign shamt     = 5'(page_shift_ff) + 5'(lvl_ff);
   assign known_bit = known_ff[cam_ff][lvl_ff];
   assign lvl_ext   = LXW'(lvl_ff);

   always_comb begin
      jump = 1'b0;
      for (int a = 0; a < 3; a++) begin
         org[a]  = rd_ff[32*a +: 32];
         diff[a] = 33'(c_ff[a]) - 33'(org[a]);
         // a move of a whole window or more on any axis
         if ((diff[a] >= PAGES) || (diff[a] <= -PAGES)) jump = 1'b1;
      end
      same = (c_ff[0] == org[0]) && (c_ff[1] == org[1]) && (c_ff[2] == org[2]);
   end

   assign out_free = !out_valid_ff || !rsp_stall;
   assign room     = !pend_valid_ff || out_free;

   // current box: whole window, or a slab on the current axis
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         bmin[a] = c_ff[a] - HALF;
         bmax[a] = c_ff[a] + HALF;
      end
      if (!full_ff) begin
         if (dpos_ff[axis_ff])      bmin[axis_ff] = org[axis_ff] + HALF;
         else if (dneg_ff[axis_ff]) bmax[axis_ff] = org[axis_ff] - HALF;
      end
   end

   always_comb begin
      stat            = '0;
      stat.walk       = (kind == KIND_POS) && req_cam_ok && active_ff[req_cam_idx] &&
                        (req_camera_moved || pending_ff[req_cam_idx]);
      stat.unchanged  = known_bit && same;
      stat.last_level = (lvl_ff == LW'(LEVELS - 1));
      stat.box_here   = full_ff || dpos_ff[axis_ff] || dneg_ff[axis_ff];
      stat.axis_last  = full_ff || (axis_ff == 2'd2);
      stat.room       = room;
      stat.pend_valid = pend_valid_ff;
      stat.out_free   = out_free;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff <= 4'(PAGE_SHIFT_RESET);
         active_ff     <= '0;
         pending_ff    <= '0;
         for (int i = 0; i < CAMERAS; i++) known_ff[i] <= '0;
      end else begin
         if (csr_we) page_shift_ff <= csr_wdata;
         if (cmd.accept) begin
            unique case (kind)
               KIND_FRAME_END: begin
                  pending_ff <= '0;
               end
               KIND_ADD: begin
                  if (req_cam_ok) begin
                     active_ff[req_cam_idx]  <= 1'b1;
                     pending_ff[req_cam_idx] <= 1'b1;
                     known_ff[req_cam_idx]   <= '0;
                  end
               end
               KIND_REMOVE: begin
                  if (req_cam_ok) active_ff[req_cam_idx] <= 1'b0;
               end
               default: begin
               end
            endcase
         end
         if (cmd.write) known_ff[cam_ff][lvl_ff] <= 1'b1;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cam_raw_ff <= req_camera;
         cam_ff     <= req_cam_idx;
         lvl_ff     <= '0;
         pos_ff[0]  <= req_pos_x;
         pos_ff[1]  <= req_pos_y;
         pos_ff[2]  <= req_pos_z;
      end else if (cmd.write && !stat.last_level) begin
         lvl_ff <= lvl_ff + LW'(1);
      end
      if (cmd.shift) begin
         for (int a = 0; a < 3; a++) c_ff[a] <= pos_ff[a] >>> shamt;
      end
      if (cmd.eval) begin
         full_ff <= !known_bit || jump;
         for (int a = 0; a < 3; a++) begin
            dpos_ff[a] <= known_bit && (diff[a] > 33'sd0);
            dneg_ff[a] <= known_bit && (diff[a] < 33'sd0);
         end
         axis_ff <= 2'd0;
      end else if (cmd.next_axis) begin
         axis_ff <= axis_ff + 2'd1;
      end
   end

   // origin memory
   always_ff @(posedge clock) begin
      if (cmd.write) mem[addr] <= {c_ff[2], c_ff[1], c_ff[0]};
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) rd_ff <= mem[addr];
   end

   // pending box and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load_box)   pend_valid_ff <= 1'b1;
         else if (cmd.flush) pend_valid_ff <= 1'b0;
         if ((cmd.load_box && pend_valid_ff) || cmd.flush) out_valid_ff <= 1'b1;
         else if (!rsp_stall)                              out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.load_box && pend_valid_ff) || cmd.flush) begin
         out_cam_ff  <= pend_cam_ff;
         out_lvl_ff  <= pend_lvl_ff;
         out_min_ff  <= pend_min_ff;
         out_max_ff  <= pend_max_ff;
         out_last_ff <= cmd.flush;
      end
      if (cmd.load_box) begin
         pend_cam_ff <= cam_raw_ff;
         pend_lvl_ff <= lvl_ext[2:0];
         pend_min_ff <= bmin;
         pend_max_ff <= bmax;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_out_camera = out_cam_ff;
   assign rsp_out_level  = out_lvl_ff;
   assign rsp_box_min_x  = out_min_ff[0];
   assign rsp_box_min_y  = out_min_ff[1];
   assign rsp_box_min_z  = out_min_ff[2];
   assign rsp_box_max_x  = out_max_ff[0];
   assign rsp_box_max_y  = out_max_ff[1];
   assign rsp_box_max_z  = out_max_ff[2];
   assign rsp_last       = out_last_ff;

endmodule

`default_nettype wire

@@ rtl/clipmap_scroll_invalidation.sv @@
// clipmap scroll invalidation: per-camera level origins and invalidation boxes
// an item that starts no walk is taken in the idle state; a walk steps each level through shift,
// eval, emit (per axis with slabs, once for a whole-window box) and write, stops at the first
// level that did not scroll or after the last level, then flushes; emit and flush wait on stall;
// one item at a time; boxes wait in a hold register for the next box or the flush so the last flag is known
// synchronous reset clears flags, known bits and handshakes, page_shift to 4; origins kept
`default_nettype none

module clipmap_scroll_invalidation
   import csi_pkg::*;
#(
   parameter int LEVELS         = 7,
   parameter int PAGES_PER_AXIS = 32,
   parameter int CAMERAS        = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_we,
   input  wire logic [3:0]         csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic [2:0]         req_camera,
   input  wire logic signed [31:0] req_pos_x,
   input  wire logic signed [31:0] req_pos_y,
   input  wire logic signed [31:0] req_pos_z,
   input  wire logic               req_camera_moved,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_out_camera,
   output logic [2:0]              rsp_out_level,
   output logic signed [31:0]      rsp_box_min_x,
   output logic signed [31:0]      rsp_box_min_y,
   output logic signed [31:0]      rsp_box_min_z,
   output logic signed [31:0]      rsp_box_max_x,
   output logic signed [31:0]      rsp_box_max_y,
   output logic signed [31:0]      rsp_box_max_z,
   output logic                    rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   csi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   csi_datapath #(
      .LEVELS         (LEVELS),
      .PAGES_PER_AXIS (PAGES_PER_AXIS),
      .CAMERAS        (CAMERAS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_kind         (req_kind),
      .req_camera       (req_camera),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_camera_moved (req_camera_moved),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_camera   (rsp_out_camera),
      .rsp_out_level    (rsp_out_level),
      .rsp_box_min_x    (rsp_box_min_x),
      .rsp_box_min_y    (rsp_box_min_y),
      .rsp_box_min_z    (rsp_box_min_z),
      .rsp_box_max_x    (rsp_box_max_x),
      .rsp_box_max_y    (rsp_box_max_y),
      .rsp_box_max_z    (rsp_box_max_z),
      .rsp_last         (rsp_last),
      .cmd              (cmd),
      .stat             (stat)
   );

endmodule

`default_nettype wire
